FILE: hdl/tsos_pkg.sv
// Package: sizes, codes and cell control types for the transpose set.
`timescale 1ns / 1ps

package tsos_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // fixed field widths of the channels
  localparam int REQ_W    = 2;
  localparam int ELEM_W   = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REWIND = 2'd2,
    REQ_NEXT   = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_state_t;

  typedef enum logic [1:0] {
    LOAD_HOLD = 2'd0,
    LOAD_KEY  = 2'd1,
    LOAD_PREV = 2'd2,
    LOAD_NEXT = 2'd3
  } cell_load_t;

  typedef struct packed {
    logic       valid;
    cell_load_t load;
  } cell_ctl_t;

endpackage

FILE: hdl/tsos_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface tsos_req_if;
  import tsos_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [ELEM_W-1:0]   elem_value;

  modport source (output valid, output req_type, output elem_value, input ready);
  modport sink   (input valid, input req_type, input elem_value, output ready);
endinterface

interface tsos_rsp_if;
  import tsos_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ELEM_W-1:0]   value_out;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output value_out, output position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input value_out, input position,
                  input entry_count, output ready);
endinterface

FILE: hdl/transpose_self_organizing_set.sv
// Top level: ordered set of distinct values kept in a row of compare cells.
//
// Requests arrive on req (req_type, elem_value); one response per request leaves
// on rsp (status, value_out, position, entry_count). Both are valid/ready.
// A request is registered in the cycle it is accepted; in the next cycle every
// cell compares its entry with the key at once, the result is formed and the
// append or the transpose swap is written into the cells. The response is
// valid the cycle after that. No new request is taken while one is in its
// compare cycle: the single compare-and-write pass over the cell row serves
// one request at a time.
// The response sits in an output register: a new request is accepted while an
// earlier response waits. If rsp stalls, the next request waits in its compare
// cycle until the output register frees, and req stays not ready meanwhile.
// Reset clears the entry count, the read cursor and the handshake state; cell
// contents are not cleared, slots at or above the count are never read.
`timescale 1ns / 1ps

module transpose_self_organizing_set
  import tsos_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tsos_req_if.sink   req,
  tsos_rsp_if.source rsp
);

  fsm_state_t state, state_next;

  req_kind_t             req_q;
  logic [VALUE_BITS-1:0] key;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      cursor, cursor_next;

  logic                  out_valid;
  status_t               status_next;
  logic [ELEM_W-1:0]     value_next;
  logic [POS_W-1:0]      pos_next;
  logic                  exec_go;

  cell_ctl_t             cell_ctl   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]   hit_vec;
  logic [CAPACITY-1:0]   hit_up;
  logic                  any_hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [VALUE_BITS-1:0] read_value;
  logic                  do_append;
  logic                  do_swap;

  // ---------------- cell row ----------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] prev_v;
    logic [VALUE_BITS-1:0] next_v;
    if (i == 0) begin : g_first
      assign prev_v = cell_value[i];
    end else begin : g_mid_prev
      assign prev_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_v = cell_value[i];
    end else begin : g_mid_next
      assign next_v = cell_value[i+1];
    end

    tsos_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .key        (key),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_value[i]),
      .hit        (hit_vec[i])
    );
  end

  assign hit_up  = hit_vec >> 1;
  assign any_hit = |hit_vec;

  // entries are distinct, so at most one hit: encode and cursor read by OR
  always_comb begin
    hit_idx    = '0;
    read_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_vec[i]) hit_idx = hit_idx | IDX_W'(i);
      if (cursor[IDX_W-1:0] == IDX_W'(i)) read_value = read_value | cell_value[i];
    end
  end

  assign exec_go   = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign do_append = exec_go && (req_q == REQ_ADD) && !any_hit &&
                     (count != CNT_W'(CAPACITY));
  assign do_swap   = exec_go && (req_q == REQ_LOOKUP) && any_hit && (hit_idx != '0);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].valid = (CNT_W'(i) < count);
      cell_ctl[i].load  = LOAD_HOLD;
      if (do_append && (CNT_W'(i) == count)) cell_ctl[i].load = LOAD_KEY;
      else if (do_swap && hit_up[i])         cell_ctl[i].load = LOAD_NEXT;
      else if (do_swap && hit_vec[i])        cell_ctl[i].load = LOAD_PREV;
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    status_next = ST_OK;
    value_next  = '0;
    pos_next    = '0;
    count_next  = count;
    cursor_next = cursor;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_next = S_IDLE;
        case (req_q)
          REQ_ADD: begin
            if (any_hit) begin
              status_next = ST_DUPLICATE;
              pos_next    = POS_W'(hit_idx);
            end else if (count == CNT_W'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              pos_next   = POS_W'(count);
              count_next = count + 1'b1;
            end
          end
          REQ_LOOKUP: begin
            if (!any_hit) begin
              status_next = ST_NOT_FOUND;
            end else begin
              value_next = ELEM_W'(key);
              pos_next   = (hit_idx == '0) ? '0 : POS_W'(hit_idx - 1'b1);
            end
          end
          REQ_REWIND: begin
            cursor_next = '0;
          end
          default: begin
            if (cursor < count) begin
              value_next  = ELEM_W'(read_value);
              pos_next    = POS_W'(cursor);
              cursor_next = cursor + 1'b1;
            end else begin
              status_next = ST_EXHAUSTED;
            end
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q <= req_kind_t'(req.req_type);
      key   <= VALUE_BITS'(req.elem_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exec_go) begin
        count     <= count_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp.status      <= status_next;
      rsp.value_out   <= value_next;
      rsp.position    <= pos_next;
      rsp.entry_count <= COUNT_W'(count_next);
    end
  end

  assign rsp.valid = out_valid;

  // ---------------- checks ----------------
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("read cursor past entry count");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    do_append |=> count == $past(count + 1'b1))
    else $error("append did not grow the count");

  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> rsp.valid)
    else $error("response beat missing after compare cycle");

  a_no_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && !exec_go |=> (state == S_EXEC))
    else $error("left compare cycle without issuing a response");

endmodule

FILE: hdl/tsos_cell.sv
// One table slot: holds an entry, compares it with the key, loads from key or neighbor.
`timescale 1ns / 1ps

module tsos_cell
  import tsos_pkg::*;
(
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] key,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic [VALUE_BITS-1:0] next_value,
  output logic [VALUE_BITS-1:0] value,
  output logic                  hit
);

  always_ff @(posedge clk) begin
    case (ctl.load)
      LOAD_KEY:  value <= key;
      LOAD_PREV: value <= prev_value;
      LOAD_NEXT: value <= next_value;
      default:   value <= value;
    endcase
  end

  assign hit = ctl.valid && (value == key);

endmodule

FILE: sim/tb_transpose_self_organizing_set.sv
// Testbench: transpose self-organizing set, random and directed requests vs. a predictor.
`timescale 1ns / 1ps

module tb_transpose_self_organizing_set;
  import tsos_pkg::*;

  localparam int TOTAL_ITEMS = 1950;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [ELEM_W-1:0] VAL_MASK =
    (VALUE_BITS >= ELEM_W) ? {ELEM_W{1'b1}} : ((ELEM_W'(1) << VALUE_BITS) - 1);

  typedef struct {
    status_t            status;
    logic [ELEM_W-1:0]  value;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] count;
  } set_rsp_t;

  // Mirrors the table contents and predicts one response per accepted request.
  class set_scoreboard;
    logic [ELEM_W-1:0] slots [CAPACITY];
    int                held;
    int                read_ptr;
    set_rsp_t          expected_rsp [$];
    int                failures;
    int                checked;
    int                n_append, n_dup, n_full, n_swap, n_miss, n_read, n_exhausted;

    function new();
      held = 0;
      read_ptr = 0;
      failures = 0;
      checked = 0;
      n_append = 0; n_dup = 0; n_full = 0; n_swap = 0;
      n_miss = 0; n_read = 0; n_exhausted = 0;
    endfunction

    function void note_request(req_kind_t kind, logic [ELEM_W-1:0] raw);
      logic [ELEM_W-1:0] v;
      int                hit;
      set_rsp_t          r;
      v = raw & VAL_MASK;
      hit = held;
      // lowest matching slot wins
      for (int i = held - 1; i >= 0; i--)
        if (slots[i] == v) hit = i;
      r.status = ST_OK;
      r.value = '0;
      r.pos = '0;
      case (kind)
        REQ_ADD: begin
          if (hit < held) begin
            r.status = ST_DUPLICATE;
            r.pos = POS_W'(hit);
            n_dup++;
          end else if (held >= CAPACITY) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            slots[held] = v;
            r.pos = POS_W'(held);
            held++;
            n_append++;
          end
        end
        REQ_LOOKUP: begin
          if (hit >= held) begin
            r.status = ST_NOT_FOUND;
            n_miss++;
          end else begin
            if (hit > 0) begin
              slots[hit] = slots[hit-1];
              slots[hit-1] = v;
              hit--;
              n_swap++;
            end
            r.value = v;
            r.pos = POS_W'(hit);
          end
        end
        REQ_REWIND: read_ptr = 0;
        default: begin
          // a swap does not move the cursor
          if (read_ptr < held) begin
            r.value = slots[read_ptr];
            r.pos = POS_W'(read_ptr);
            read_ptr++;
            n_read++;
          end else begin
            r.status = ST_EXHAUSTED;
            n_exhausted++;
          end
        end
      endcase
      r.count = COUNT_W'(held);
      expected_rsp.push_back(r);
    endfunction

    function void field_check(string tag, logic [ELEM_W-1:0] exp_v,
                              logic [ELEM_W-1:0] act_v);
      if (exp_v !== act_v) begin
        failures++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, tag, exp_v, act_v);
      end
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [ELEM_W-1:0] val,
                                 logic [POS_W-1:0] pos, logic [COUNT_W-1:0] cnt);
      set_rsp_t e;
      if (expected_rsp.size() == 0) begin
        failures++;
        $display("%0t: response with nothing outstanding: expected none, %s %0d value %0h",
                 $time, "actual status", st, val);
        return;
      end
      e = expected_rsp.pop_front();
      checked++;
      field_check("status", ELEM_W'(e.status), ELEM_W'(st));
      field_check("value_out", e.value, val);
      field_check("position", ELEM_W'(e.pos), ELEM_W'(pos));
      field_check("entry_count", ELEM_W'(e.count), ELEM_W'(cnt));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tsos_req_if req_ch ();
  tsos_rsp_if rsp_ch ();

  transpose_self_organizing_set uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  set_scoreboard sb = new();

  int items_sent = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  int long_hold = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitors; values read here are the ones before this edge's updates
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request(req_kind_t'(req_ch.req_type), req_ch.elem_value);
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.status, rsp_ch.value_out, rsp_ch.position, rsp_ch.entry_count);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish, %0d results outstanding", $time,
               sb.expected_rsp.size());
      $display("tb: failure");
      $finish;
    end
  end

  // response side: random stall bursts, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        hold_left = long_hold;
        long_hold = 0;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left = $urandom_range(0, 16);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic sender_gap(input int n);
    req_ch.valid <= 1'b0;
    req_ch.elem_value <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input req_kind_t kind, input logic [ELEM_W-1:0] val);
    if (idle_on && $urandom_range(0, 4) == 0)
      sender_gap($urandom_range(1, 17));
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.elem_value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] any_held_value();
    if (sb.held == 0) return $urandom;
    return sb.slots[$urandom_range(0, sb.held - 1)];
  endfunction

  initial begin
    int r;
    int pick;
    bit hold_done;
    bit drain_done;
    logic [ELEM_W-1:0] val;
    hold_done = 1'b0;
    drain_done = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ADD;
    req_ch.elem_value = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, duplicates, front hit, swap, cursor effects
    send_item(REQ_NEXT, 32'h0);
    send_item(REQ_LOOKUP, 32'h0);
    send_item(REQ_ADD, 32'h0000_0000);
    send_item(REQ_ADD, 32'hFFFF_FFFF);
    send_item(REQ_ADD, 32'h8000_0001);
    send_item(REQ_ADD, 32'h0000_0000);
    send_item(REQ_ADD, 32'hFFFF_FFFF);
    send_item(REQ_LOOKUP, 32'h0000_0000);
    send_item(REQ_LOOKUP, 32'h8000_0001);
    send_item(REQ_LOOKUP, 32'h8000_0001);
    send_item(REQ_LOOKUP, 32'h1234_5678);
    send_item(REQ_REWIND, 32'hDEAD_BEEF);
    send_item(REQ_NEXT, 32'hFFFF_FFFF);
    send_item(REQ_LOOKUP, 32'hFFFF_FFFF);  // moves into the cursor slot before it is read
    send_item(REQ_NEXT, 32'h0);
    send_item(REQ_NEXT, 32'h0);
    send_item(REQ_NEXT, 32'h0);
    send_item(REQ_NEXT, 32'h5555_5555);
    send_item(REQ_LOOKUP, 32'h0000_0000);
    send_item(REQ_REWIND, 32'h0);
    send_item(REQ_NEXT, 32'hAAAA_AAAA);

    while (items_sent < TOTAL_ITEMS) begin
      idle_on = (items_sent < TOTAL_ITEMS - 250);

      if (!hold_done && items_sent >= 700) begin
        // response side stops for a long stretch while requests keep coming
        hold_done = 1'b1;
        long_hold = 250;
        repeat (12) send_item(REQ_LOOKUP, any_held_value());
      end
      if (!drain_done && items_sent >= 1100) begin
        drain_done = 1'b1;
        wait_all_results();
      end

      r = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (r < 2) begin
        // full cursor walk past the end
        send_item(REQ_REWIND, $urandom);
        repeat (sb.held + 2) send_item(REQ_NEXT, $urandom);
      end else if (r < 27) begin
        if (pick < 3 || sb.held == 0) val = $urandom;
        else if (pick < 8) val = any_held_value();
        else val = any_held_value() ^ (32'h1 << $urandom_range(0, 31));
        send_item(REQ_ADD, val);
      end else if (r < 60) begin
        if (pick < 7) val = any_held_value();
        else if (pick < 9) val = any_held_value() ^ (32'h1 << $urandom_range(0, 31));
        else val = $urandom;
        send_item(REQ_LOOKUP, val);
      end else if (r < 68) begin
        send_item(REQ_REWIND, $urandom);
      end else begin
        send_item(REQ_NEXT, $urandom);
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run: %0d requests, %0d responses checked, table held %0d entries at the end",
             items_sent, sb.checked, sb.held);
    $display("Run: %0d appends, %0d duplicates, %0d full, %0d swaps, %0d misses, %s",
             sb.n_append, sb.n_dup, sb.n_full, sb.n_swap, sb.n_miss,
             $sformatf("%0d reads, %0d exhausted", sb.n_read, sb.n_exhausted));
    if (sb.failures == 0 && sb.expected_rsp.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
